### rtl/core/pqc_pkg.sv
// Shared types, operation codes and result kinds for the packet queue chunker.
// Used by every module under rtl/core; depends on nothing.
package pqc_pkg;

    localparam int QUEUE_DEPTH_DEF   = 8;
    localparam int PACKET_BYTES_DEF  = 1029;
    localparam int CHUNK_PAYLOAD_DEF = 32;
    localparam int JOBQ_DEPTH        = 4;
    localparam int HDR_BYTES         = 5;
    localparam int ADDR_W            = 17;
    localparam int PLEN_W            = 6;

    localparam logic [1:0] OP_PUSH  = 2'd0;
    localparam logic [1:0] OP_FETCH = 2'd1;
    localparam logic [1:0] OP_STATS = 2'd2;
    localparam logic [1:0] OP_CLEAR = 2'd3;

    localparam logic [1:0] KIND_PUSH  = 2'd0;
    localparam logic [1:0] KIND_CHUNK = 2'd1;
    localparam logic [1:0] KIND_STATS = 2'd2;
    localparam logic [1:0] KIND_NONE  = 2'd3;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  out_byte;
        logic        end_of_chunk;
        logic        accepted;
        logic [3:0]  held_packets;
        logic [6:0]  usage_percent;
        logic        warning;
        logic [3:0]  peak_packets;
        logic [31:0] attempts_total;
        logic [31:0] dropped_total;
        logic [31:0] sent_total;
    } res_t;

    typedef struct packed {
        logic              is_chunk;
        res_t              base;
        logic [3:0][7:0]   hdr;
        logic [ADDR_W-1:0] addr;
        logic [PLEN_W-1:0] plen;
    } job_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } mem_wr_t;

endpackage

### rtl/core/pqc_jobq.sv
// Small job queue between the front and the back of the packet queue chunker.
// Depends on pqc_pkg for the job record.
module pqc_jobq #(
    parameter int DEPTH = pqc_pkg::JOBQ_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  pqc_pkg::job_t din,
    output logic          full,
    input  logic          pop,
    output pqc_pkg::job_t dout,
    output logic          empty
);
    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    pqc_pkg::job_t   slot_reg [DEPTH];
    logic [PW-1:0]   wptr_reg;
    logic [PW-1:0]   rptr_reg;
    logic [CW-1:0]   cnt_reg;
    logic            do_push;
    logic            do_pop;

    assign full    = (cnt_reg == CW'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = slot_reg[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wptr_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wptr_reg <= (wptr_reg == PW'(DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rptr_reg <= (rptr_reg == PW'(DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + CW'(do_push) - CW'(do_pop);
        end
    end

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(DEPTH))
        else $error("job queue count out of range");
    a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> cnt_reg == $past(cnt_reg) + 1'b1)
        else $error("job queue count did not advance");
    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == '0) |-> (wptr_reg == rptr_reg))
        else $error("job queue pointers disagree with count");
endmodule

### rtl/core/pqc_front.sv
// Front of the packet queue chunker: takes items, keeps the packet ring state
// and counters, and issues jobs and packet-store writes. Depends on pqc_pkg.
module pqc_front #(
    parameter int QUEUE_DEPTH   = pqc_pkg::QUEUE_DEPTH_DEF,
    parameter int PACKET_BYTES  = pqc_pkg::PACKET_BYTES_DEF,
    parameter int CHUNK_PAYLOAD = pqc_pkg::CHUNK_PAYLOAD_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [1:0]        op,
    input  logic [7:0]        data,
    input  logic              last,
    input  logic              pkt_class,
    input  logic              warn_we,
    input  logic [6:0]        warn_data,
    input  logic              chunk_done,
    output logic              job_push,
    output pqc_pkg::job_t     job,
    output pqc_pkg::mem_wr_t  wr,
    output logic              chunk_pend
);
    localparam int SW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int LW = $clog2(PACKET_BYTES + 2);
    localparam int PW = $clog2(CHUNK_PAYLOAD + 1);

    logic [LW-1:0] len_arr  [QUEUE_DEPTH];
    logic [7:0]    id_arr   [QUEUE_DEPTH];
    logic          type_arr [QUEUE_DEPTH];
    logic [7:0]    nxt_arr  [QUEUE_DEPTH];
    logic [7:0]    tot_arr  [QUEUE_DEPTH];
    logic          done_arr [QUEUE_DEPTH];
    logic [6:0]    pct_tab  [QUEUE_DEPTH + 1];

    logic [SW-1:0] head_reg, head_next, tail_reg, tail_next;
    logic [CW-1:0] held_reg, held_next, peak_reg, peak_next;
    logic [7:0]    id_reg, id_next;
    logic [LW-1:0] wo_reg, wo_next;
    logic          disc_reg, disc_next;
    logic [PW-1:0] fill_reg, fill_next;
    logic [7:0]    chunks_reg, chunks_next;
    logic [31:0]   att_reg, att_next, drop_reg, drop_next, sent_reg, sent_next;
    logic [6:0]    warn_reg;
    logic          pend_reg, pend_next;

    logic          first, disc_now, retire, is_push, is_fetch, ent_wr, fch_wr;
    logic [LW-1:0] wo_inc, off, rem;
    logic [SW-1:0] s;
    logic [PW-1:0] plen;
    logic [7:0]    nc, tot_new;
    logic [6:0]    usage;
    logic          acc;

    for (genvar g = 0; g <= QUEUE_DEPTH; g++)
    begin : g_pct
        assign pct_tab[g] = 7'((g * 100) / QUEUE_DEPTH);
    end

    function automatic logic [SW-1:0] wrap_inc(input logic [SW-1:0] i);
        return (i == SW'(QUEUE_DEPTH - 1)) ? '0 : i + 1'b1;
    endfunction

    always_comb
    begin
        head_next   = head_reg;
        tail_next   = tail_reg;
        held_next   = held_reg;
        peak_next   = peak_reg;
        id_next     = id_reg;
        wo_next     = wo_reg;
        disc_next   = disc_reg;
        fill_next   = fill_reg;
        chunks_next = chunks_reg;
        att_next    = att_reg;
        drop_next   = drop_reg;
        sent_next   = sent_reg;
        pend_next   = pend_reg && !chunk_done;
        job_push    = 1'b0;
        job         = '0;
        wr          = '0;
        acc         = 1'b0;
        ent_wr      = 1'b0;
        fch_wr      = 1'b0;
        is_push     = accept && (op == pqc_pkg::OP_PUSH);
        is_fetch    = accept && (op == pqc_pkg::OP_FETCH);
        first       = (wo_reg == '0);
        disc_now    = first ? (held_reg >= CW'(QUEUE_DEPTH)) : disc_reg;
        wo_inc      = (wo_reg <= LW'(PACKET_BYTES)) ? wo_reg + 1'b1 : wo_reg;
        retire      = (held_reg != '0) && done_arr[tail_reg];
        s           = retire ? wrap_inc(tail_reg) : tail_reg;
        nc          = nxt_arr[s];
        off         = LW'(32'(nc) * CHUNK_PAYLOAD);
        rem         = (len_arr[s] > off) ? len_arr[s] - off : '0;
        plen        = (rem > LW'(CHUNK_PAYLOAD)) ? PW'(CHUNK_PAYLOAD) : PW'(rem);
        tot_new     = 8'd0;

        if (is_push)
        begin
            if (!disc_now && wo_reg < LW'(PACKET_BYTES))
            begin
                wr.en   = 1'b1;
                wr.addr = pqc_pkg::ADDR_W'(head_reg) * pqc_pkg::ADDR_W'(PACKET_BYTES)
                        + pqc_pkg::ADDR_W'(wo_reg);
                wr.data = data;
            end
            if (first)
            begin
                fill_next   = PW'(1);
                chunks_next = 8'd1;
            end
            else if (fill_reg == '0)
            begin
                fill_next   = PW'(1);
                chunks_next = chunks_reg + 8'd1;
            end
            else
            begin
                fill_next = (fill_reg == PW'(CHUNK_PAYLOAD - 1)) ? '0 : fill_reg + 1'b1;
            end
            tot_new = (first ? pkt_class : type_arr[head_reg]) ? 8'd1 : chunks_next;
            if (!last)
            begin
                wo_next   = wo_inc;
                disc_next = disc_now;
            end
            else
            begin
                wo_next   = '0;
                disc_next = 1'b0;
                if (wo_inc <= LW'(PACKET_BYTES))
                begin
                    att_next = att_reg + 32'd1;
                    if (disc_now)
                    begin
                        drop_next = drop_reg + 32'd1;
                    end
                    else
                    begin
                        ent_wr    = 1'b1;
                        id_next   = id_reg + 8'd1;
                        head_next = wrap_inc(head_reg);
                        held_next = held_reg + 1'b1;
                        if (held_next > peak_reg)
                        begin
                            peak_next = held_next;
                        end
                        acc = 1'b1;
                    end
                end
                job_push = 1'b1;
            end
        end
        else if (is_fetch)
        begin
            if (retire)
            begin
                sent_next = sent_reg + 32'd1;
                tail_next = s;
                held_next = held_reg - 1'b1;
            end
            job_push = 1'b1;
            if (held_next != '0)
            begin
                fch_wr    = 1'b1;
                pend_next = 1'b1;
            end
        end
        else if (accept)
        begin
            job_push = 1'b1;
            if (op == pqc_pkg::OP_CLEAR)
            begin
                att_next  = '0;
                drop_next = '0;
                sent_next = '0;
                peak_next = '0;
            end
        end

        usage = pct_tab[held_next];
        job.base.held_packets   = 4'(held_next);
        job.base.usage_percent  = usage;
        job.base.warning        = (usage >= warn_reg);
        job.base.peak_packets   = 4'(peak_next);
        job.base.attempts_total = att_next;
        job.base.dropped_total  = drop_next;
        job.base.sent_total     = sent_next;
        job.base.end_of_chunk   = 1'b1;
        job.base.accepted       = acc;
        unique case (op)
            pqc_pkg::OP_PUSH:  job.base.kind = pqc_pkg::KIND_PUSH;
            pqc_pkg::OP_FETCH: job.base.kind = fch_wr ? pqc_pkg::KIND_CHUNK
                                                      : pqc_pkg::KIND_NONE;
            default:           job.base.kind = pqc_pkg::KIND_STATS;
        endcase
        job.is_chunk = fch_wr;
        job.hdr[0]   = {7'd0, type_arr[s]};
        job.hdr[1]   = id_arr[s];
        job.hdr[2]   = nc;
        job.hdr[3]   = tot_arr[s];
        job.addr     = pqc_pkg::ADDR_W'(s) * pqc_pkg::ADDR_W'(PACKET_BYTES)
                     + pqc_pkg::ADDR_W'(off);
        job.plen     = pqc_pkg::PLEN_W'(plen);
    end

    assign chunk_pend = pend_reg;

    always_ff @(posedge clk)
    begin
        if (is_push && first && !disc_now)
        begin
            type_arr[head_reg] <= pkt_class;
        end
        if (ent_wr)
        begin
            len_arr[head_reg]  <= wo_inc;
            id_arr[head_reg]   <= id_reg;
            nxt_arr[head_reg]  <= 8'd0;
            tot_arr[head_reg]  <= tot_new;
            done_arr[head_reg] <= 1'b0;
        end
        if (fch_wr)
        begin
            nxt_arr[s]  <= nc + 8'd1;
            done_arr[s] <= ((nc + 8'd1) >= tot_arr[s]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg   <= '0;
            tail_reg   <= '0;
            held_reg   <= '0;
            peak_reg   <= '0;
            id_reg     <= '0;
            wo_reg     <= '0;
            disc_reg   <= 1'b0;
            fill_reg   <= '0;
            chunks_reg <= '0;
            att_reg    <= '0;
            drop_reg   <= '0;
            sent_reg   <= '0;
            warn_reg   <= 7'd80;
            pend_reg   <= 1'b0;
        end
        else
        begin
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            held_reg   <= held_next;
            peak_reg   <= peak_next;
            id_reg     <= id_next;
            wo_reg     <= wo_next;
            disc_reg   <= disc_next;
            fill_reg   <= fill_next;
            chunks_reg <= chunks_next;
            att_reg    <= att_next;
            drop_reg   <= drop_next;
            sent_reg   <= sent_next;
            pend_reg   <= pend_next;
            if (warn_we)
            begin
                warn_reg <= warn_data;
            end
        end
    end

    a_held_range: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg <= CW'(QUEUE_DEPTH))
        else $error("held count above queue depth");
    a_peak_covers: assert property (@(posedge clk) disable iff (!rst_n)
        (is_push && last && acc) |=> peak_reg >= held_reg)
        else $error("peak below held count after accepted packet");
    a_no_write_pend: assert property (@(posedge clk) disable iff (!rst_n)
        wr.en |-> !pend_reg)
        else $error("packet store written while a chunk is streaming");
endmodule

### rtl/core/pqc_back.sv
// Back of the packet queue chunker: owns the packet store and serializes each
// job into result items in an output register. Depends on pqc_pkg.
module pqc_back #(
    parameter int QUEUE_DEPTH  = pqc_pkg::QUEUE_DEPTH_DEF,
    parameter int PACKET_BYTES = pqc_pkg::PACKET_BYTES_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  pqc_pkg::mem_wr_t wr,
    input  logic             job_valid,
    input  pqc_pkg::job_t    job,
    output logic             job_pop,
    input  logic             pop,
    output pqc_pkg::res_t    res,
    output logic             res_valid,
    output logic             chunk_done
);
    localparam int MAW = $clog2(QUEUE_DEPTH * PACKET_BYTES);
    localparam int SW  = pqc_pkg::PLEN_W;

    logic [7:0]            mem [QUEUE_DEPTH * PACKET_BYTES];
    logic [7:0]            rd_data;
    logic                  rd_en;
    logic [pqc_pkg::ADDR_W-1:0] rd_addr;
    logic                  busy_reg;
    pqc_pkg::job_t         job_reg;
    logic [SW-1:0]         step_reg;
    pqc_pkg::res_t         res_reg;
    pqc_pkg::res_t         res_next;
    logic                  valid_reg;
    logic                  adv, fin;
    logic [SW:0]           step_inc, last_step;

    assign job_pop   = !busy_reg && job_valid;
    assign adv       = busy_reg && (!valid_reg || pop);
    assign step_inc  = {1'b0, step_reg} + 1'b1;
    assign last_step = (SW + 1)'(job_reg.plen) + (SW + 1)'(pqc_pkg::HDR_BYTES - 1);
    assign fin       = !job_reg.is_chunk || ({1'b0, step_reg} == last_step);
    assign rd_en     = adv && !fin && (step_inc >= (SW + 1)'(pqc_pkg::HDR_BYTES));
    assign rd_addr   = job_reg.addr + pqc_pkg::ADDR_W'(step_inc)
                     - pqc_pkg::ADDR_W'(pqc_pkg::HDR_BYTES);
    assign chunk_done = adv && fin && job_reg.is_chunk;
    assign res       = res_reg;
    assign res_valid = valid_reg;

    always_comb
    begin
        res_next = job_reg.base;
        if (job_reg.is_chunk)
        begin
            res_next.end_of_chunk = fin;
            if (step_reg < SW'(pqc_pkg::HDR_BYTES - 1))
            begin
                res_next.out_byte = job_reg.hdr[step_reg[1:0]];
            end
            else if (step_reg == SW'(pqc_pkg::HDR_BYTES - 1))
            begin
                res_next.out_byte = 8'd0;
            end
            else
            begin
                res_next.out_byte = rd_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr[MAW-1:0]] <= wr.data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr[MAW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_pop)
        begin
            job_reg <= job;
        end
        if (adv)
        begin
            res_reg <= res_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            step_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (job_pop)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (adv)
            begin
                busy_reg <= !fin;
                step_reg <= step_inc[SW-1:0];
            end
            if (adv)
            begin
                valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && job_reg.is_chunk) |-> ({1'b0, step_reg} <= last_step))
        else $error("chunk step beyond last byte");
    a_single_one: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && !job_reg.is_chunk) |=> !busy_reg)
        else $error("single result job did not finish in one step");
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        chunk_done |-> busy_reg)
        else $error("chunk done while idle");
endmodule

### rtl/core/packet_queue_chunker.sv
// Top level of the packet queue chunker: front, job queue and back.
// Path: with the back idle, an accepted item's job passes the job queue, the
// back's job register and its output register before its first result shows.
// Throughput: bytes not ending a packet are taken one per cycle while full is low;
// the back takes a new job only once done with the last, so single-result items
// back up into the four-entry job queue. A fetch that finds a packet streams
// 5 + payload bytes at one per cycle when popped; input stalls until the chunk is out.
// Reset: asynchronous active low clears pointers, counters and queues;
// the packet store needs no clearing.
module packet_queue_chunker #(
    parameter int QUEUE_DEPTH   = pqc_pkg::QUEUE_DEPTH_DEF,
    parameter int PACKET_BYTES  = pqc_pkg::PACKET_BYTES_DEF,
    parameter int CHUNK_PAYLOAD = pqc_pkg::CHUNK_PAYLOAD_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  op,
    input  logic [7:0]  data,
    input  logic        last,
    input  logic        pkt_class,
    input  logic        warn_percent_we,
    input  logic [6:0]  warn_percent,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  kind,
    output logic [7:0]  out_byte,
    output logic        end_of_chunk,
    output logic        accepted,
    output logic [3:0]  held_packets,
    output logic [6:0]  usage_percent,
    output logic        warning,
    output logic [3:0]  peak_packets,
    output logic [31:0] attempts_total,
    output logic [31:0] dropped_total,
    output logic [31:0] sent_total
);
    pqc_pkg::job_t    fj, bj;
    pqc_pkg::mem_wr_t wr;
    pqc_pkg::res_t    res;
    logic             job_push, jq_full, jq_empty, job_pop, chunk_done, chunk_pend;
    logic             res_valid, accept;

    assign full   = jq_full || chunk_pend;
    assign accept = push && !full;

    pqc_front #(
        .QUEUE_DEPTH   (QUEUE_DEPTH),
        .PACKET_BYTES  (PACKET_BYTES),
        .CHUNK_PAYLOAD (CHUNK_PAYLOAD)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .op          (op),
        .data        (data),
        .last        (last),
        .pkt_class   (pkt_class),
        .warn_we     (warn_percent_we),
        .warn_data   (warn_percent),
        .chunk_done  (chunk_done),
        .job_push    (job_push),
        .job         (fj),
        .wr          (wr),
        .chunk_pend  (chunk_pend)
    );

    pqc_jobq #(
        .DEPTH (pqc_pkg::JOBQ_DEPTH)
    ) u_jobq (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (job_push),
        .din   (fj),
        .full  (jq_full),
        .pop   (job_pop),
        .dout  (bj),
        .empty (jq_empty)
    );

    pqc_back #(
        .QUEUE_DEPTH  (QUEUE_DEPTH),
        .PACKET_BYTES (PACKET_BYTES)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr         (wr),
        .job_valid  (!jq_empty),
        .job        (bj),
        .job_pop    (job_pop),
        .pop        (pop),
        .res        (res),
        .res_valid  (res_valid),
        .chunk_done (chunk_done)
    );

    assign empty          = !res_valid;
    assign kind           = res.kind;
    assign out_byte       = res.out_byte;
    assign end_of_chunk   = res.end_of_chunk;
    assign accepted       = res.accepted;
    assign held_packets   = res.held_packets;
    assign usage_percent  = res.usage_percent;
    assign warning        = res.warning;
    assign peak_packets   = res.peak_packets;
    assign attempts_total = res.attempts_total;
    assign dropped_total  = res.dropped_total;
    assign sent_total     = res.sent_total;
endmodule
